// File: design/pep_pkg.sv
`default_nettype none

package pep_pkg;

  // Layout of one 128-byte partition entry.
  localparam int EntryBytes = 128;
  localparam logic [6:0] OffTypeEnd  = 7'd16;
  localparam logic [6:0] OffStart    = 7'd32;
  localparam logic [6:0] OffEnd      = 7'd40;
  localparam logic [6:0] OffAttr     = 7'd48;
  localparam logic [6:0] OffName     = 7'd56;
  localparam logic [6:0] OffLast     = 7'(EntryBytes - 1);

  // Result kinds.
  localparam logic KindName    = 1'b0;
  localparam logic KindSummary = 1'b1;

  // Type classes.
  localparam logic [2:0] ClassEfi     = 3'd0;
  localparam logic [2:0] ClassBasic   = 3'd1;
  localparam logic [2:0] ClassSwap    = 3'd2;
  localparam logic [2:0] ClassRoot    = 3'd3;
  localparam logic [2:0] ClassUnused  = 3'd4;
  localparam logic [2:0] ClassUnknown = 3'd5;

  localparam logic [6:0] CharUnknown = 7'h3F;

  // Result queue between parser and output stage.
  localparam int QueueDepth  = 4;
  localparam int QueuePtrW   = 2;
  localparam int QueueCountW = 3;

  // Known type identifiers in on-disk byte order.
  localparam logic [0:3][0:15][7:0] TypeGuids = '{
    '{8'h28, 8'h73, 8'h2A, 8'hC1, 8'h1F, 8'hF8, 8'hD2, 8'h11,
      8'hBA, 8'h4B, 8'h00, 8'hA0, 8'hC9, 8'h3E, 8'hC9, 8'h3B},
    '{8'hA2, 8'hA0, 8'hD0, 8'hEB, 8'hE5, 8'hB9, 8'h33, 8'h44,
      8'h87, 8'hC0, 8'h68, 8'hB6, 8'hB7, 8'h26, 8'h99, 8'hC7},
    '{8'h6D, 8'hFD, 8'h57, 8'h06, 8'hAB, 8'hA4, 8'hC4, 8'h43,
      8'h84, 8'hE5, 8'h09, 8'h33, 8'hC8, 8'h4B, 8'h4F, 8'h4F},
    '{8'hE3, 8'hBC, 8'h68, 8'h4F, 8'hCD, 8'hE8, 8'hB1, 8'h4D,
      8'h96, 8'hE7, 8'hFB, 8'hCA, 8'hF9, 8'h84, 8'hB7, 8'h09}
  };

  typedef struct packed {
    logic        kind;
    logic [7:0]  entry_index;
    logic        entry_valid;
    logic [2:0]  type_class;
    logic [63:0] start_block;
    logic [63:0] end_block;
    logic [63:0] sector_total;
    logic [63:0] attribute_bits;
    logic [8:0]  valid_total;
    logic [6:0]  name_char;
    logic        last;
  } result_t;

  // Zero, one or two results produced by one byte, in delivery order.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

`default_nettype wire

// File: design/partition_entry_array_parser.sv
// A byte's first result passes through the result queue and then the output register.
// Throughput: one byte per cycle unless stalled; the second result of a byte that yields two waits in
// the four-entry result queue, so the output register sets the sustained rate.
// Bytes are held off while fewer than two queue slots are free.
// Reset (rst, synchronous, active high) clears the parser state, empties the queue and output,
// and sets entry_count to 128.
`default_nettype none

module partition_entry_array_parser #(
  parameter int MAX_ENTRIES = 256
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // Byte request channel.
  input  wire logic         byte_valid,
  output logic              byte_stall,
  input  wire logic [7:0]   data_byte,
  input  wire logic         table_start,
  // Configuration write channel.
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [8:0]   cfg_data,
  // Result request channel.
  output logic              result_valid,
  input  wire logic         result_stall,
  output logic              kind,
  output logic [7:0]        entry_index,
  output logic              entry_valid,
  output logic [2:0]        type_class,
  output logic [63:0]       start_block,
  output logic [63:0]       end_block,
  output logic [63:0]       sector_total,
  output logic [63:0]       attribute_bits,
  output logic [8:0]        valid_total,
  output logic [6:0]        name_char,
  output logic              last
);

  // The only register in this module: how many entries of the array are parsed.
  logic [8:0] entry_count;

  logic                                 take;
  pep_pkg::push_t                       push;
  pep_pkg::result_t                     head;
  pep_pkg::result_t                     result;
  logic                                 not_empty;
  logic                                 pop;
  logic [pep_pkg::QueueCountW-1:0]      level;

  // Configuration is always taken; the user must write it only while the block is idle (not enforced here).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= 9'd128;
    end else if (cfg_valid && cfg_ready) begin
      entry_count <= cfg_data;
    end
  end

  // A byte may produce up to two results, so it is only taken while two slots are free.
  // The stall depends on the registered queue level alone.
  assign byte_stall = (level > pep_pkg::QueueCountW'(pep_pkg::QueueDepth - 2));
  assign take       = byte_valid && !byte_stall;

  // Front end: tracks the offset within the entry, collects fields and classifies the type.
  pep_front #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .data_byte   (data_byte),
    .table_start (table_start),
    .entry_count (entry_count),
    .push        (push)
  );

  // Short queue that decouples the parser from the output handshake.
  pep_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .level     (level)
  );

  // Back end: registered output that presents one result per request.
  pep_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .not_empty    (not_empty),
    .result_stall (result_stall),
    .pop          (pop),
    .result_valid (result_valid),
    .result       (result)
  );

  assign kind           = result.kind;
  assign entry_index    = result.entry_index;
  assign entry_valid    = result.entry_valid;
  assign type_class     = result.type_class;
  assign start_block    = result.start_block;
  assign end_block      = result.end_block;
  assign sector_total   = result.sector_total;
  assign attribute_bits = result.attribute_bits;
  assign valid_total    = result.valid_total;
  assign name_char      = result.name_char;
  assign last           = result.last;

  // The queue never overflows, even when a two-result byte arrives.
  assert property (@(posedge clk) disable iff (rst)
    level <= pep_pkg::QueueCountW'(pep_pkg::QueueDepth))
    else $error("result queue overflow");

  // A summary for an entry with an all-zero type carries the unused class and no start, sector or attribute fields.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && kind == pep_pkg::KindSummary && !entry_valid) |->
      (type_class == pep_pkg::ClassUnused && start_block == 64'd0 &&
       sector_total == 64'd0 && attribute_bits == 64'd0))
    else $error("invalid entry summary carries field data");

  // Name characters only come from valid entries and carry none of the summary fields.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && kind == pep_pkg::KindName) |->
      (entry_valid && valid_total == 9'd0 && type_class == pep_pkg::ClassEfi))
    else $error("malformed name character result");

  // A queued result never enters the output register while a stalled one is held.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |-> !pop)
    else $error("output register overwritten while stalled");

endmodule

`default_nettype wire

// File: design/pep_front.sv
`default_nettype none

module pep_front #(
  parameter int MAX_ENTRIES = 256
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         take,
  input  wire logic [7:0]   data_byte,
  input  wire logic         table_start,
  input  wire logic [8:0]   entry_count,
  output pep_pkg::push_t    push
);

  logic [6:0]  byte_offset, byte_offset_next;
  logic [8:0]  current_index, current_index_next;
  logic [8:0]  valid_counter, valid_counter_next;
  logic        type_nonzero, type_nonzero_next;
  logic [3:0]  type_match_flags, type_match_flags_next;
  logic [63:0] start_accum, start_accum_next;
  logic [63:0] end_accum, end_accum_next;
  logic [63:0] attribute_accum, attribute_accum_next;
  logic [7:0]  name_low_byte, name_low_byte_next;
  logic        name_ended, name_ended_next;

  logic [6:0]  off;
  logic [8:0]  idx;
  logic [8:0]  vcount;
  logic        past_limit;
  logic        entry_clear;
  logic        tn_b;
  logic [3:0]  flags_b;
  logic [63:0] start_b, end_b, attr_b;
  logic [7:0]  nlb_b;
  logic        ne_b;
  logic [63:0] lane_byte;
  logic [15:0] unit;
  logic        char_hit;
  logic [6:0]  char_val;
  logic        sum_hit;
  logic [8:0]  vcount_new;
  logic [2:0]  tclass;
  logic [3:0]  mismatch;
  pep_pkg::result_t name_item, sum_item;

  always_comb begin
    off    = table_start ? 7'd0 : byte_offset;
    idx    = table_start ? 9'd0 : current_index;
    vcount = table_start ? 9'd0 : valid_counter;
    past_limit = (idx >= entry_count) || (32'(idx) >= 32'(MAX_ENTRIES));

    entry_clear = (off == 7'd0);
    tn_b    = entry_clear ? 1'b0   : type_nonzero;
    flags_b = entry_clear ? 4'hF   : type_match_flags;
    start_b = entry_clear ? 64'd0  : start_accum;
    end_b   = entry_clear ? 64'd0  : end_accum;
    attr_b  = entry_clear ? 64'd0  : attribute_accum;
    nlb_b   = entry_clear ? 8'd0   : name_low_byte;
    ne_b    = entry_clear ? 1'b0   : name_ended;

    lane_byte = 64'(data_byte) << {off[2:0], 3'b000};
    unit      = {data_byte, nlb_b};
    for (int g = 0; g < 4; g++) begin
      mismatch[g] = (pep_pkg::TypeGuids[g][off[3:0]] != data_byte);
    end

    byte_offset_next      = byte_offset;
    current_index_next    = current_index;
    valid_counter_next    = valid_counter;
    type_nonzero_next     = type_nonzero;
    type_match_flags_next = type_match_flags;
    start_accum_next      = start_accum;
    end_accum_next        = end_accum;
    attribute_accum_next  = attribute_accum;
    name_low_byte_next    = name_low_byte;
    name_ended_next       = name_ended;
    char_hit = 1'b0;
    char_val = (unit < 16'h0080) ? unit[6:0] : pep_pkg::CharUnknown;
    sum_hit  = 1'b0;

    if (take) begin
      byte_offset_next   = off;
      current_index_next = idx;
      valid_counter_next = vcount;
      if (!past_limit) begin
        type_nonzero_next     = tn_b;
        type_match_flags_next = flags_b;
        start_accum_next      = start_b;
        end_accum_next        = end_b;
        attribute_accum_next  = attr_b;
        name_low_byte_next    = nlb_b;
        name_ended_next       = ne_b;

        if (off < pep_pkg::OffTypeEnd) begin
          if (data_byte != 8'd0) begin
            type_nonzero_next = 1'b1;
          end
          type_match_flags_next = flags_b & ~mismatch;
        end else if (off >= pep_pkg::OffStart && off < pep_pkg::OffEnd) begin
          start_accum_next = start_b | lane_byte;
        end else if (off >= pep_pkg::OffEnd && off < pep_pkg::OffAttr) begin
          end_accum_next = end_b | lane_byte;
        end else if (off >= pep_pkg::OffAttr && off < pep_pkg::OffName) begin
          attribute_accum_next = attr_b | lane_byte;
        end else if (off >= pep_pkg::OffName) begin
          if (!off[0]) begin
            name_low_byte_next = data_byte;
          end else if (tn_b && !ne_b) begin
            if (unit == 16'd0) begin
              name_ended_next = 1'b1;
            end else begin
              char_hit = 1'b1;
            end
          end
        end

        if (off == pep_pkg::OffLast) begin
          sum_hit = 1'b1;
          current_index_next = idx + 9'd1;
          byte_offset_next   = 7'd0;
        end else begin
          byte_offset_next = off + 7'd1;
        end
        if (sum_hit && tn_b) begin
          valid_counter_next = vcount_new;
        end
      end
    end
  end

  // Saturating count of valid entries including the one now closing.
  assign vcount_new = (vcount != 9'h1FF) ? vcount + 9'd1 : vcount;

  always_comb begin
    if (flags_b[0]) begin
      tclass = pep_pkg::ClassEfi;
    end else if (flags_b[1]) begin
      tclass = pep_pkg::ClassBasic;
    end else if (flags_b[2]) begin
      tclass = pep_pkg::ClassSwap;
    end else if (flags_b[3]) begin
      tclass = pep_pkg::ClassRoot;
    end else begin
      tclass = pep_pkg::ClassUnknown;
    end

    name_item = '0;
    name_item.kind        = pep_pkg::KindName;
    name_item.entry_index = idx[7:0];
    name_item.entry_valid = 1'b1;
    name_item.type_class  = pep_pkg::ClassEfi;
    name_item.name_char   = char_val;
    name_item.last        = !sum_hit;

    sum_item = '0;
    sum_item.kind        = pep_pkg::KindSummary;
    sum_item.entry_index = idx[7:0];
    sum_item.last        = 1'b1;
    if (tn_b) begin
      sum_item.entry_valid    = 1'b1;
      sum_item.type_class     = tclass;
      sum_item.start_block    = start_b;
      sum_item.end_block      = end_b;
      sum_item.sector_total   = end_b - start_b + 64'd1;
      sum_item.attribute_bits = attr_b;
      sum_item.valid_total    = vcount_new;
    end else begin
      sum_item.type_class  = pep_pkg::ClassUnused;
      sum_item.valid_total = vcount;
    end

    push = '0;
    if (char_hit && sum_hit) begin
      push.count  = 2'd2;
      push.first  = name_item;
      push.second = sum_item;
    end else if (char_hit) begin
      push.count = 2'd1;
      push.first = name_item;
    end else if (sum_hit) begin
      push.count = 2'd1;
      push.first = sum_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset      <= '0;
      current_index    <= '0;
      valid_counter    <= '0;
      type_nonzero     <= 1'b0;
      type_match_flags <= 4'hF;
      start_accum      <= '0;
      end_accum        <= '0;
      attribute_accum  <= '0;
      name_low_byte    <= '0;
      name_ended       <= 1'b0;
    end else begin
      byte_offset      <= byte_offset_next;
      current_index    <= current_index_next;
      valid_counter    <= valid_counter_next;
      type_nonzero     <= type_nonzero_next;
      type_match_flags <= type_match_flags_next;
      start_accum      <= start_accum_next;
      end_accum        <= end_accum_next;
      attribute_accum  <= attribute_accum_next;
      name_low_byte    <= name_low_byte_next;
      name_ended       <= name_ended_next;
    end
  end

endmodule

`default_nettype wire

// File: design/pep_queue.sv
`default_nettype none

module pep_queue (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire pep_pkg::push_t                    push,
  input  wire logic                              pop,
  output pep_pkg::result_t                       head,
  output logic                                   not_empty,
  output logic [pep_pkg::QueueCountW-1:0]        level
);

  pep_pkg::result_t mem [pep_pkg::QueueDepth];
  logic [pep_pkg::QueuePtrW-1:0]   wr_ptr;
  logic [pep_pkg::QueuePtrW-1:0]   rd_ptr;
  logic [pep_pkg::QueueCountW-1:0] count;

  // Two results from one byte land in consecutive slots.
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + pep_pkg::QueuePtrW'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + pep_pkg::QueuePtrW'(push.count);
      rd_ptr <= rd_ptr + pep_pkg::QueuePtrW'(pop);
      count  <= count + pep_pkg::QueueCountW'(push.count) - pep_pkg::QueueCountW'(pop);
    end
  end

  assign head      = mem[rd_ptr];
  assign not_empty = (count != '0);
  assign level     = count;

endmodule

`default_nettype wire

// File: design/pep_back.sv
`default_nettype none

module pep_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire pep_pkg::result_t  head,
  input  wire logic              not_empty,
  input  wire logic              result_stall,
  output logic                   pop,
  output logic                   result_valid,
  output pep_pkg::result_t       result
);

  logic load;

  // The output register refills whenever it is empty or being taken.
  assign load = !result_valid || !result_stall;
  assign pop  = load && not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= not_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result <= head;
    end
  end

endmodule

`default_nettype wire
